[rtl/core/bvm_pkg.sv]
// bvm_pkg: shared constants, types and state encodings for the battery voltage monitor
package bvm_pkg;

	localparam int BURST_SAMPLES = 5;
	localparam int MAX_VALID_MV  = 20000;
	localparam int ADC_BITS      = 12;
	localparam int SAMPLE_W      = 12;
	localparam int IDX_W         = (BURST_SAMPLES > 1) ? $clog2(BURST_SAMPLES) : 1;
	localparam int CNT_W         = $clog2(BURST_SAMPLES + 1);
	localparam int NOMINAL_TEMP  = 400;

	localparam logic [2:0] REG_GAIN     = 3'd0;
	localparam logic [2:0] REG_FLOODED  = 3'd1;
	localparam logic [2:0] REG_FALLBACK = 3'd2;
	localparam logic [2:0] REG_ALPHA    = 3'd3;
	localparam logic [2:0] REG_LOW      = 3'd4;
	localparam logic [2:0] REG_CRIT     = 3'd5;
	localparam logic [2:0] REG_HYST     = 3'd6;
	localparam logic [2:0] REG_MINCONN  = 3'd7;

	typedef struct packed {
		logic [23:0]        gain_q16;
		logic               flooded_mode;
		logic signed [11:0] fallback_temperature;
		logic [15:0]        alpha_q16;
		logic [15:0]        low_threshold_mv;
		logic [15:0]        critical_threshold_mv;
		logic [11:0]        hysteresis_mv;
		logic [15:0]        min_connected_mv;
	} cfg_t;

	typedef struct packed {
		logic        upd;
		logic [15:0] median;
	} q_entry_t;

	typedef enum logic [1:0] {F_IDLE, F_SCALE, F_PICK} front_state_t;
	typedef enum logic [1:0] {B_IDLE, B_MUL1, B_MUL2, B_SUM} back_state_t;

endpackage

[rtl/core/bvm_front.sv]
// bvm_front: takes a burst, scales samples one per cycle, picks the median
module bvm_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bvm_pkg::cfg_t                   cfg,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [bvm_pkg::SAMPLE_W-1:0]    samples [bvm_pkg::BURST_SAMPLES],
	input  logic                            temp_valid,
	input  logic signed [11:0]              temp_reading,
	output logic                            push,
	output bvm_pkg::q_entry_t               push_entry,
	input  logic                            q_full
);

	bvm_pkg::front_state_t state_q, state_nxt;
	logic [bvm_pkg::IDX_W-1:0]   idx_q;
	logic [bvm_pkg::ADC_BITS-1:0] raw_q [bvm_pkg::BURST_SAMPLES];
	logic [15:0]                 vals_q [bvm_pkg::BURST_SAMPLES];
	logic [bvm_pkg::BURST_SAMPLES-1:0] vld_q;
	logic signed [12:0]          adj_q;
	logic signed [11:0]          sensor_temp_q;
	logic                        have_sensor_q;

	logic               accept;
	logic signed [11:0] t_sel;
	logic signed [13:0] t_diff;
	logic signed [15:0] t_x3;
	logic signed [15:0] adj_full;
	logic [35:0]        prod;
	logic signed [21:0] mv;
	logic               mv_ok;
	logic [bvm_pkg::CNT_W-1:0] cnt;
	logic [bvm_pkg::CNT_W-1:0] rank [bvm_pkg::BURST_SAMPLES];
	logic [15:0]        median;
	logic               last;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != bvm_pkg::F_IDLE);
	assign last     = (idx_q == bvm_pkg::IDX_W'(bvm_pkg::BURST_SAMPLES - 1));

	// a fresh sensor reading applies to the burst that carries it
	always_comb begin
		if (temp_valid)
			t_sel = temp_reading;
		else if (have_sensor_q)
			t_sel = sensor_temp_q;
		else
			t_sel = cfg.fallback_temperature;
		t_diff   = 14'(bvm_pkg::NOMINAL_TEMP) - 14'(t_sel);
		t_x3     = 16'(t_diff) * 16'sd3;
		adj_full = cfg.flooded_mode ? (t_x3 >>> 1) : 16'sd0;
	end

	always_comb begin
		prod  = 36'(raw_q[idx_q]) * 36'(cfg.gain_q16);
		mv    = 22'($signed({2'b00, prod[35:16]})) + 22'(adj_q);
		mv_ok = !mv[21] && (mv <= 22'(bvm_pkg::MAX_VALID_MV));
	end

	// rank with index tie-break gives a stable sort position for each valid sample
	always_comb begin
		cnt    = '0;
		median = '0;
		for (int i = 0; i < bvm_pkg::BURST_SAMPLES; i++)
			cnt = cnt + bvm_pkg::CNT_W'(vld_q[i]);
		for (int i = 0; i < bvm_pkg::BURST_SAMPLES; i++) begin
			rank[i] = '0;
			for (int j = 0; j < bvm_pkg::BURST_SAMPLES; j++)
				if (vld_q[j] && ((vals_q[j] < vals_q[i]) || (vals_q[j] == vals_q[i] && j < i)))
					rank[i] = rank[i] + 1'b1;
		end
		for (int i = 0; i < bvm_pkg::BURST_SAMPLES; i++)
			if (vld_q[i] && rank[i] == (cnt >> 1))
				median = vals_q[i];
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bvm_pkg::F_IDLE:  if (accept) state_nxt = bvm_pkg::F_SCALE;
			bvm_pkg::F_SCALE: if (last) state_nxt = bvm_pkg::F_PICK;
			bvm_pkg::F_PICK:  if (!q_full) state_nxt = bvm_pkg::F_IDLE;
			default:          state_nxt = bvm_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		push       = (state_q == bvm_pkg::F_PICK) && !q_full;
		push_entry = '{upd: (cnt != '0), median: median};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= bvm_pkg::F_IDLE;
			idx_q         <= '0;
			have_sensor_q <= 1'b0;
			sensor_temp_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				idx_q <= '0;
				if (temp_valid) begin
					have_sensor_q <= 1'b1;
					sensor_temp_q <= temp_reading;
				end
			end else if (state_q == bvm_pkg::F_SCALE && !last) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			adj_q <= 13'(adj_full);
			for (int i = 0; i < bvm_pkg::BURST_SAMPLES; i++)
				raw_q[i] <= samples[i][bvm_pkg::ADC_BITS-1:0];
		end
		if (state_q == bvm_pkg::F_SCALE) begin
			vals_q[idx_q] <= mv[15:0];
			vld_q[idx_q]  <= mv_ok;
		end
	end

endmodule

[rtl/core/bvm_queue.sv]
// bvm_queue: two-entry word queue between front and back
module bvm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bvm_pkg::q_entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output bvm_pkg::q_entry_t head,
	output logic              empty
);

	bvm_pkg::q_entry_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

endmodule

[rtl/core/bvm_back.sv]
// bvm_back: EMA update, hysteresis flags and output register
module bvm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bvm_pkg::cfg_t     cfg,
	input  logic              q_empty,
	input  bvm_pkg::q_entry_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       voltage_mv,
	output logic              updated,
	output logic              connected,
	output logic              is_low,
	output logic              is_critical,
	output logic              low_entered,
	output logic              critical_entered
);

	bvm_pkg::back_state_t state_q, state_nxt;
	bvm_pkg::q_entry_t ent_q;
	logic [31:0] smoothed_q;
	logic        have_q, low_flag_q, crit_flag_q;
	logic [48:0] p1_s1;
	logic [31:0] p2_s2;
	logic        out_valid_q;

	logic        out_free, fin;
	logic [49:0] sum;
	logic [31:0] s_new;
	logic        conn, low_n, crit_n, low_ev, crit_ev;
	logic [16:0] low_clr, crit_clr;

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == bvm_pkg::B_IDLE) && !q_empty;
	assign fin       = (state_q == bvm_pkg::B_SUM) && out_free;
	assign out_valid = out_valid_q;

	always_comb begin
		sum      = 50'(p1_s1) + {2'b00, p2_s2, 16'h0000};
		if (!ent_q.upd)
			s_new = smoothed_q;
		else if (!have_q)
			s_new = {ent_q.median, 16'h0000};
		else
			s_new = sum[47:16];
		conn     = s_new > {cfg.min_connected_mv, 16'h0000};
		low_clr  = 17'(cfg.low_threshold_mv) + 17'(cfg.hysteresis_mv);
		crit_clr = 17'(cfg.critical_threshold_mv) + 17'(cfg.hysteresis_mv);
		low_n    = low_flag_q;
		crit_n   = crit_flag_q;
		low_ev   = 1'b0;
		crit_ev  = 1'b0;
		if (ent_q.upd) begin
			if (!conn) begin
				low_n  = 1'b0;
				crit_n = 1'b0;
			end else begin
				if (!low_flag_q && s_new < {cfg.low_threshold_mv, 16'h0000}) begin
					low_n  = 1'b1;
					low_ev = 1'b1;
				end else if (low_flag_q && {1'b0, s_new} > {low_clr, 16'h0000}) begin
					low_n = 1'b0;
				end
				if (!crit_flag_q && s_new < {cfg.critical_threshold_mv, 16'h0000}) begin
					crit_n  = 1'b1;
					crit_ev = 1'b1;
				end else if (crit_flag_q && {1'b0, s_new} > {crit_clr, 16'h0000}) begin
					crit_n = 1'b0;
				end
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bvm_pkg::B_IDLE: if (!q_empty) state_nxt = bvm_pkg::B_MUL1;
			bvm_pkg::B_MUL1: state_nxt = bvm_pkg::B_MUL2;
			bvm_pkg::B_MUL2: state_nxt = bvm_pkg::B_SUM;
			bvm_pkg::B_SUM:  if (out_free) state_nxt = bvm_pkg::B_IDLE;
			default:         state_nxt = bvm_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bvm_pkg::B_IDLE;
			smoothed_q  <= '0;
			have_q      <= 1'b0;
			low_flag_q  <= 1'b0;
			crit_flag_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (fin) begin
				smoothed_q  <= s_new;
				have_q      <= have_q | ent_q.upd;
				low_flag_q  <= low_n;
				crit_flag_q <= crit_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) ent_q <= head;
		if (state_q == bvm_pkg::B_MUL1)
			p1_s1 <= 49'(smoothed_q) * 49'(17'h10000 - 17'(cfg.alpha_q16));
		if (state_q == bvm_pkg::B_MUL2)
			p2_s2 <= 32'(ent_q.median) * 32'(cfg.alpha_q16);
		if (fin) begin
			voltage_mv       <= s_new[31:16];
			updated          <= ent_q.upd;
			connected        <= conn;
			is_low           <= low_n;
			is_critical      <= crit_n;
			low_entered      <= low_ev;
			critical_entered <= crit_ev;
		end
	end

endmodule

[rtl/core/battery_voltage_monitor_top.sv]
// battery_voltage_monitor_top: register file and front/queue/back assembly
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | sample_0..sample_4, temp_valid, temp_reading
//  output  | out_valid | out_stall | voltage_mv, updated, connected, flags, events
//  config  | cfg_we    | -         | cfg_index, cfg_data
//
// The front takes a burst only when idle, then one sample per cycle goes through the
// single scaling multiplier, then the median pick, which waits while the queue is full.
// The back takes one word at a time: pop, two multiplies, then sum and flag update.
// A two-word queue sits between them; out_stall holds the back, and the front once the queue fills.
// Reset clears all filter state and loads the register defaults.
module battery_voltage_monitor_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [11:0]        sample_0,
	input  logic [11:0]        sample_1,
	input  logic [11:0]        sample_2,
	input  logic [11:0]        sample_3,
	input  logic [11:0]        sample_4,
	input  logic               temp_valid,
	input  logic signed [11:0] temp_reading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        voltage_mv,
	output logic               updated,
	output logic               connected,
	output logic               is_low,
	output logic               is_critical,
	output logic               low_entered,
	output logic               critical_entered
);

	bvm_pkg::cfg_t     cfg_q;
	bvm_pkg::q_entry_t push_entry, head;
	logic push, pop, q_full, q_empty;
	logic [11:0] all_samples [5];
	logic [bvm_pkg::SAMPLE_W-1:0] samples [bvm_pkg::BURST_SAMPLES];

	assign all_samples = '{sample_0, sample_1, sample_2, sample_3, sample_4};

	always_comb begin
		for (int i = 0; i < bvm_pkg::BURST_SAMPLES; i++)
			samples[i] = all_samples[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_q16              <= 24'd52813;
			cfg_q.flooded_mode          <= 1'b1;
			cfg_q.fallback_temperature  <= 12'sd400;
			cfg_q.alpha_q16             <= 16'd2149;
			cfg_q.low_threshold_mv      <= 16'd12000;
			cfg_q.critical_threshold_mv <= 16'd11500;
			cfg_q.hysteresis_mv         <= 12'd200;
			cfg_q.min_connected_mv      <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bvm_pkg::REG_GAIN:     cfg_q.gain_q16              <= cfg_data;
				bvm_pkg::REG_FLOODED:  cfg_q.flooded_mode          <= cfg_data[0];
				bvm_pkg::REG_FALLBACK: cfg_q.fallback_temperature  <= cfg_data[11:0];
				bvm_pkg::REG_ALPHA:    cfg_q.alpha_q16             <= cfg_data[15:0];
				bvm_pkg::REG_LOW:      cfg_q.low_threshold_mv      <= cfg_data[15:0];
				bvm_pkg::REG_CRIT:     cfg_q.critical_threshold_mv <= cfg_data[15:0];
				bvm_pkg::REG_HYST:     cfg_q.hysteresis_mv         <= cfg_data[11:0];
				bvm_pkg::REG_MINCONN:  cfg_q.min_connected_mv      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	bvm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.samples      (samples),
		.temp_valid   (temp_valid),
		.temp_reading (temp_reading),
		.push         (push),
		.push_entry   (push_entry),
		.q_full       (q_full)
	);

	bvm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty)
	);

	bvm_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_empty          (q_empty),
		.head             (head),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.voltage_mv       (voltage_mv),
		.updated          (updated),
		.connected        (connected),
		.is_low           (is_low),
		.is_critical      (is_critical),
		.low_entered      (low_entered),
		.critical_entered (critical_entered)
	);

endmodule

[bench/battery_voltage_monitor_top_tb.sv]
// battery_voltage_monitor_top_tb: self-checking bench with burst driver, result monitor and predictor
module battery_voltage_monitor_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [11:0]        smp [5];
		logic               tv;
		logic signed [11:0] tr;
	} burst_t;

	typedef struct {
		logic [15:0] mv;
		logic        upd;
		logic        conn;
		logic        low;
		logic        crit;
		logic        low_ev;
		logic        crit_ev;
	} reading_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = bvm_pkg::REG_GAIN;
	logic [23:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [11:0]        sample_0 = '0, sample_1 = '0, sample_2 = '0, sample_3 = '0, sample_4 = '0;
	logic               temp_valid = 1'b0;
	logic signed [11:0] temp_reading = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [15:0]        voltage_mv;
	logic               updated, connected, is_low, is_critical, low_entered, critical_entered;

	battery_voltage_monitor_top DUT (.*);

	always #5 clk = ~clk;

	// register copy
	logic [23:0]        m_gain = 24'd52813;
	logic               m_flooded = 1'b1;
	logic signed [11:0] m_fallback = 12'sd400;
	logic [15:0]        m_alpha = 16'd2149;
	logic [15:0]        m_low = 16'd12000;
	logic [15:0]        m_crit = 16'd11500;
	logic [11:0]        m_hyst = 12'd200;
	logic [15:0]        m_minconn = 16'd1000;

	// filter state copy
	logic [31:0]        ema_q16 = '0;
	logic               ema_seeded = 1'b0;
	logic signed [11:0] probe_temp = '0;
	logic               probe_seen = 1'b0;
	logic               low_alarm = 1'b0;
	logic               crit_alarm = 1'b0;

	burst_t   bursts_to_send [$];
	reading_t readings_due [$];
	burst_t   cur;
	int       errors = 0;
	int       sent = 0;
	int       checked = 0;
	int       settings = 1;
	int       in_gap = 0;
	int       out_hold = 0;
	int       pressure_left = 0;
	bit       pressure_done = 0;
	bit       in_steady = 0;
	bit       out_steady = 0;

	function automatic reading_t predict_reading(burst_t b);
		longint   kept [$];
		longint   mv, med, s, lowq, critq, hq;
		int       t, adj;
		reading_t r;
		if (b.tv) begin
			probe_temp = b.tr;
			probe_seen = 1'b1;
		end
		t = probe_seen ? int'(probe_temp) : int'(m_fallback);
		adj = m_flooded ? (((bvm_pkg::NOMINAL_TEMP - t) * 3) >>> 1) : 0;
		for (int i = 0; i < bvm_pkg::BURST_SAMPLES; i++) begin
			mv = ((longint'(b.smp[i]) * longint'(m_gain)) >>> 16) + adj;
			if (mv >= 0 && mv <= bvm_pkg::MAX_VALID_MV)
				kept = {kept, mv};
		end
		r.upd = 1'b0;
		r.low_ev = 1'b0;
		r.crit_ev = 1'b0;
		if (kept.size() > 0) begin
			kept.sort();
			med = kept[kept.size() / 2];
			r.upd = 1'b1;
			if (!ema_seeded) begin
				ema_q16 = 32'(med << 16);
				ema_seeded = 1'b1;
			end else begin
				s = (longint'(ema_q16) * (65536 - longint'(m_alpha)) +
					(med << 16) * longint'(m_alpha)) >>> 16;
				ema_q16 = 32'(s);
			end
			s = longint'(ema_q16);
			lowq = longint'(m_low) << 16;
			critq = longint'(m_crit) << 16;
			hq = longint'(m_hyst) << 16;
			if (s > (longint'(m_minconn) << 16)) begin
				if (!low_alarm && s < lowq) begin
					low_alarm = 1'b1;
					r.low_ev = 1'b1;
				end else if (low_alarm && s > lowq + hq)
					low_alarm = 1'b0;
				if (!crit_alarm && s < critq) begin
					crit_alarm = 1'b1;
					r.crit_ev = 1'b1;
				end else if (crit_alarm && s > critq + hq)
					crit_alarm = 1'b0;
			end else begin
				low_alarm = 1'b0;
				crit_alarm = 1'b0;
			end
		end
		r.mv = ema_q16[31:16];
		r.conn = longint'(ema_q16) > (longint'(m_minconn) << 16);
		r.low = low_alarm;
		r.crit = crit_alarm;
		return r;
	endfunction

	function automatic int pick_gap(bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void check_field(string name, int exp, int got);
		if (exp != got) begin
			$error("%s expected %0d got %0d", name, exp, got);
			errors++;
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				readings_due = {readings_due, predict_reading(cur)};
				sent++;
				in_gap = pick_gap(in_steady);
				if ($urandom_range(0, 99) == 0)
					in_steady = ~in_steady;
			end
			if (!(in_valid && in_stall)) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (bursts_to_send.size() > 0) begin
					cur = bursts_to_send.pop_front();
					sample_0 <= cur.smp[0];
					sample_1 <= cur.smp[1];
					sample_2 <= cur.smp[2];
					sample_3 <= cur.smp[3];
					sample_4 <= cur.smp[4];
					temp_valid <= cur.tv;
					temp_reading <= cur.tr;
					in_valid <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		reading_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (readings_due.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					e = readings_due.pop_front();
					check_field("voltage_mv", e.mv, voltage_mv);
					check_field("updated", e.upd, updated);
					check_field("connected", e.conn, connected);
					check_field("is_low", e.low, is_low);
					check_field("is_critical", e.crit, is_critical);
					check_field("low_entered", e.low_ev, low_entered);
					check_field("critical_entered", e.crit_ev, critical_entered);
					checked++;
				end
			end
			// long hold so the input side backs up
			if (!pressure_done && sent >= 400) begin
				pressure_done = 1;
				pressure_left = 300;
			end
			if (pressure_left > 0) begin
				pressure_left--;
				out_stall <= 1'b1;
			end else if (out_hold > 0) begin
				out_hold--;
				out_stall <= 1'b1;
			end else begin
				out_hold = pick_gap(out_steady);
				if ($urandom_range(0, 99) == 0)
					out_steady = ~out_steady;
				out_stall <= (out_hold > 0);
				if (out_hold > 0)
					out_hold--;
			end
		end
	end

	task automatic set_reg(logic [2:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			bvm_pkg::REG_GAIN:     m_gain = val;
			bvm_pkg::REG_FLOODED:  m_flooded = val[0];
			bvm_pkg::REG_FALLBACK: m_fallback = val[11:0];
			bvm_pkg::REG_ALPHA:    m_alpha = val[15:0];
			bvm_pkg::REG_LOW:      m_low = val[15:0];
			bvm_pkg::REG_CRIT:     m_crit = val[15:0];
			bvm_pkg::REG_HYST:     m_hyst = val[11:0];
			bvm_pkg::REG_MINCONN:  m_minconn = val[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (bursts_to_send.size() != 0 || readings_due.size() != 0 || in_valid)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic push_flat(int r0, int r1, int r2, int r3, int r4);
		burst_t b;
		b.smp[0] = 12'(r0); b.smp[1] = 12'(r1); b.smp[2] = 12'(r2);
		b.smp[3] = 12'(r3); b.smp[4] = 12'(r4);
		b.tv = 1'b0;
		b.tr = '0;
		bursts_to_send = {bursts_to_send, b};
	endtask

	initial begin
		#10_000_000;
		$display("battery_voltage_monitor_top_tb: errors");
		$finish;
	end

	initial begin
		burst_t b;
		int     target, raw, lo, hi;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// defaults: seed on first word, raw extremes, all five samples valid in every burst
		push_flat(0, 0, 0, 0, 0);
		push_flat(4095, 4095, 4095, 4095, 4095);
		push_flat(4095, 0, 4095, 0, 2000);
		push_flat(1, 2, 4, 8, 16);
		push_flat(2048, 1024, 512, 256, 128);
		drain();

		// coarse gain: full scale exceeds the valid window
		set_reg(bvm_pkg::REG_GAIN, 24'd400000);
		set_reg(bvm_pkg::REG_ALPHA, 24'd65535);
		settings++;
		push_flat(4095, 4095, 4095, 4095, 4095);   // nothing valid
		push_flat(3000, 3000, 3000, 3000, 3000);   // above both thresholds
		push_flat(1000, 1000, 1000, 1000, 1000);   // both alarms set
		push_flat(1950, 1950, 1950, 1950, 1950);   // between thresholds
		push_flat(2100, 4095, 4095, 4095, 2100);   // three dropped, even count
		push_flat(100, 100, 100, 100, 100);        // disconnected clears alarms
		push_flat(1000, 4095, 1000, 4095, 4095);
		push_flat(3300, 3200, 3100, 4000, 0);
		push_flat(0, 4095, 0, 4095, 0);
		push_flat(1, 3277, 3276, 3278, 1);
		drain();

		for (int p = 0; p < 8; p++) begin
			set_reg(bvm_pkg::REG_GAIN, 24'($urandom_range(150000, 600000)));
			set_reg(bvm_pkg::REG_FLOODED, 24'($urandom_range(0, 1)));
			set_reg(bvm_pkg::REG_FALLBACK, 24'($urandom_range(0, 2880) - 880));
			set_reg(bvm_pkg::REG_ALPHA, 24'($urandom_range(4000, 65535)));
			set_reg(bvm_pkg::REG_LOW, 24'($urandom_range(6000, 16000)));
			set_reg(bvm_pkg::REG_CRIT, 24'(m_low - $urandom_range(0, 1500)));
			set_reg(bvm_pkg::REG_HYST, 24'($urandom_range(0, 800)));
			set_reg(bvm_pkg::REG_MINCONN, 24'($urandom_range(500, 4000)));
			case (p)
				0: begin
					set_reg(bvm_pkg::REG_GAIN, 24'hFFFFFF);
					set_reg(bvm_pkg::REG_ALPHA, 24'd65535);
				end
				1: begin
					set_reg(bvm_pkg::REG_GAIN, 24'd0);
					set_reg(bvm_pkg::REG_FLOODED, 24'd0);
				end
				2: begin
					set_reg(bvm_pkg::REG_ALPHA, 24'd1);
					set_reg(bvm_pkg::REG_HYST, 24'd0);
					set_reg(bvm_pkg::REG_MINCONN, 24'd0);
				end
				3: begin
					set_reg(bvm_pkg::REG_HYST, 24'd4095);
					set_reg(bvm_pkg::REG_FALLBACK, 24'(-880));
					set_reg(bvm_pkg::REG_FLOODED, 24'd1);
				end
				4: begin
					set_reg(bvm_pkg::REG_FALLBACK, 24'd2000);
					set_reg(bvm_pkg::REG_FLOODED, 24'd1);
					set_reg(bvm_pkg::REG_MINCONN, 24'd65535);
				end
				5: begin
					set_reg(bvm_pkg::REG_ALPHA, 24'd0);
					set_reg(bvm_pkg::REG_FALLBACK, 24'h800);
				end
				default: ;
			endcase
			settings++;
			target = m_low + m_hyst / 2;
			for (int n = 0; n < 210; n++) begin
				target += int'($urandom_range(0, 800)) - 400;
				if ($urandom_range(0, 99) < 3)
					target = int'($urandom_range(0, m_minconn));
				lo = int'(m_crit) - int'(m_hyst) - 1500;
				hi = int'(m_low) + int'(m_hyst) + 1500;
				if (target < lo) target = lo;
				if (target > hi) target = hi;
				if (target < 0) target = 0;
				if (target > 21000) target = 21000;
				raw = (m_gain == 0) ? int'($urandom_range(0, 4095))
					: int'((longint'(target) * 65536) / m_gain);
				if (raw > 4095) raw = 4095;
				if ($urandom_range(0, 99) < 85) begin
					for (int k = 0; k < 5; k++) begin
						b.smp[k] = 12'(raw + int'($urandom_range(0, 16)) - 8);
						if (raw < 8 || raw > 4087)
							b.smp[k] = 12'(raw);
					end
					if ($urandom_range(0, 3) == 0)
						b.smp[$urandom_range(0, 4)] = 12'($urandom_range(0, 4095));
				end else
					for (int k = 0; k < 5; k++)
						b.smp[k] = 12'($urandom_range(0, 4095));
				b.tv = 1'b0;
				b.tr = 12'($urandom_range(0, 4095));
				// sensor kept off until the fallback settings have been exercised
				if (p >= 6 && (n == 0 || $urandom_range(0, 9) == 0)) begin
					b.tv = 1'b1;
					case ($urandom_range(0, 3))
						0: b.tr = -12'sd880;
						1: b.tr = 12'sd2000;
						default: b.tr = 12'($urandom_range(0, 4095));
					endcase
				end
				bursts_to_send = {bursts_to_send, b};
			end
			drain();
		end

		$display("checked %0d result words from %0d bursts across %0d register settings",
			checked, sent, settings);
		$display("output hold-off pressure applied: %0d", pressure_done);
		if (errors == 0 && readings_due.size() == 0)
			$display("battery_voltage_monitor_top_tb: clean");
		else
			$display("battery_voltage_monitor_top_tb: errors");
		$finish;
	end

endmodule

[battery_voltage_monitor_top.f]
rtl/core/bvm_pkg.sv
rtl/core/bvm_front.sv
rtl/core/bvm_queue.sv
rtl/core/bvm_back.sv
rtl/core/battery_voltage_monitor_top.sv
bench/battery_voltage_monitor_top_tb.sv
